@@ rtl/expression_token_scanner_top_assert.svh @@
// Assertion macros for the expression token scanner RTL.
// No dependencies; included by ets_token_fifo, the module that carries assertions.
`ifndef EXPRESSION_TOKEN_SCANNER_TOP_ASSERT_SVH
`define EXPRESSION_TOKEN_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define ETS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define ETS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ets_pkg.sv @@
// Package for the expression token scanner: widths, codes, token types and helpers.
// No dependencies; imported by every module of the block.
package ets_pkg;

    localparam int ROW_BITS    = 20;
    localparam int COLUMN_BITS = 16;
    localparam int OFFSET_BITS = 32;
    localparam int CP_BITS     = 21;
    localparam int KIND_BITS   = 4;
    localparam int VALUE_BITS  = 64;
    localparam int TAB_BITS    = 3;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef logic [ROW_BITS-1:0]    t_row;
    typedef logic [COLUMN_BITS-1:0] t_col;
    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [CP_BITS-1:0]     t_cp;
    typedef logic [KIND_BITS-1:0]   t_kind;
    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [TAB_BITS-1:0]    t_tab;

    localparam logic [2:0] PK_NONE    = 3'd0;
    localparam logic [2:0] PK_NEWLINE = 3'd1;
    localparam logic [2:0] PK_BLANKS  = 3'd2;
    localparam logic [2:0] PK_NUMBER  = 3'd3;
    localparam logic [2:0] PK_IDENT   = 3'd4;

    localparam t_kind TK_NEWLINE = 4'd0;
    localparam t_kind TK_BLANKS  = 4'd1;
    localparam t_kind TK_COLON   = 4'd2;
    localparam t_kind TK_COMMA   = 4'd3;
    localparam t_kind TK_LPAREN  = 4'd4;
    localparam t_kind TK_RPAREN  = 4'd5;
    localparam t_kind TK_EQUALS  = 4'd6;
    localparam t_kind TK_PLUS    = 4'd7;
    localparam t_kind TK_MINUS   = 4'd8;
    localparam t_kind TK_STAR    = 4'd9;
    localparam t_kind TK_SLASH   = 4'd10;
    localparam t_kind TK_NUMBER  = 4'd11;
    localparam t_kind TK_IDENT   = 4'd12;
    localparam t_kind TK_INVALID = 4'd13;

    localparam t_cp CH_END    = 21'd0;
    localparam t_cp CH_TAB    = 21'd9;
    localparam t_cp CH_LF     = 21'd10;
    localparam t_cp CH_CR     = 21'd13;
    localparam t_cp CH_SPACE  = 21'd32;
    localparam t_cp CH_LPAREN = 21'd40;
    localparam t_cp CH_RPAREN = 21'd41;
    localparam t_cp CH_STAR   = 21'd42;
    localparam t_cp CH_PLUS   = 21'd43;
    localparam t_cp CH_COMMA  = 21'd44;
    localparam t_cp CH_MINUS  = 21'd45;
    localparam t_cp CH_SLASH  = 21'd47;
    localparam t_cp CH_ZERO   = 21'd48;
    localparam t_cp CH_NINE   = 21'd57;
    localparam t_cp CH_COLON  = 21'd58;
    localparam t_cp CH_EQUALS = 21'd61;
    localparam t_cp CH_UP_A   = 21'd65;
    localparam t_cp CH_UP_Z   = 21'd90;
    localparam t_cp CH_UNDER  = 21'd95;
    localparam t_cp CH_LO_A   = 21'd97;
    localparam t_cp CH_LO_Z   = 21'd122;

    localparam t_tab TAB_RESET = 3'd2;
    localparam logic [2:0] ADDR_TAB_STOP = 3'd0;

    typedef struct packed {
        t_kind  kind;
        t_row   begin_row;
        t_col   begin_column;
        t_row   end_row;
        t_col   end_column;
        t_off   begin_offset;
        t_value number_value;
        logic   last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok_a;
        t_token     tok_b;
    } t_push;

    function automatic t_row sat_inc_row(input t_row v);
        return (v == '1) ? v : v + t_row'(1);
    endfunction

    function automatic t_col sat_inc_col(input t_col v);
        return (v == '1) ? v : v + t_col'(1);
    endfunction

    function automatic t_col advance_blank(input t_col v, input logic is_tab, input t_tab tsl);
        t_col w;
        w = is_tab ? (v | ((t_col'(1) << tsl) - t_col'(1))) : v;
        return sat_inc_col(w);
    endfunction

endpackage

@@ rtl/expression_token_scanner_top.sv @@
// Expression token scanner: one code point per transaction in, one token per transaction out.
// A tab-stop register sits behind an APB-style port; uses the input stage, ets_lexer, ets_token_fifo.
// The input channel takes one code point and its byte offset per transaction into an input
// register. When the token queue has room for two tokens the character is scanned
// combinationally and the zero, one or two tokens it completes are written to a four-entry queue.
// The first token of a character is offered one clock edge after the transaction, and a
// new code point may be taken in every cycle, so one character per cycle is sustained while
// the receiver keeps up; output is at most one token per cycle, set by the queue read port.
// A stalled receiver fills the queue, after which the input register holds its character
// and ready drops until two entries are free again. The last flag marks the final token a
// character produced. A code point of zero flushes the pending token and homes the cursor.
// Reset clears the queue, empties the input register, drops any pending token, puts the
// cursor at row 0, column 0 and sets the tab stop exponent to 2. The configuration register
// lies at byte address 0; the user must write it only while the block is idle; this is not checked.
module expression_token_scanner_top
    import ets_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cp         i_code_point,
    input  t_off        i_byte_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output t_kind       o_token_kind,
    output t_row        o_begin_row,
    output t_col        o_begin_column,
    output t_row        o_end_row,
    output t_col        o_end_column,
    output t_off        o_begin_offset,
    output t_value      o_number_value,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic   r_in_valid;
    t_cp    r_cp;
    t_off   r_off;
    t_tab   r_tab;
    logic   room2, proc;
    t_push  push;
    t_token head;

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_TAB_STOP) ? {29'd0, r_tab} : 32'd0;
    assign proc    = r_in_valid && room2;
    assign o_ready = !r_in_valid || room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab <= TAB_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_TAB_STOP)) begin
            r_tab <= pwdata[TAB_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cp  <= i_code_point;
            r_off <= i_byte_offset;
        end
    end

    ets_lexer u_lexer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (proc),
        .i_code_point    (r_cp),
        .i_byte_offset   (r_off),
        .i_tab_stop_log2 (r_tab),
        .o_push          (push)
    );

    ets_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_ready),
        .o_room2 (room2),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_token_kind   = head.kind;
    assign o_begin_row    = head.begin_row;
    assign o_begin_column = head.begin_column;
    assign o_end_row      = head.end_row;
    assign o_end_column   = head.end_column;
    assign o_begin_offset = head.begin_offset;
    assign o_number_value = head.number_value;
    assign o_last         = head.last;

endmodule

@@ rtl/ets_lexer.sv @@
// Scanner state and per-character token logic for the expression token scanner.
// Depends on ets_pkg; produces up to two tokens per processed character.
module ets_lexer
    import ets_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_fire,
    input  t_cp    i_code_point,
    input  t_off   i_byte_offset,
    input  t_tab   i_tab_stop_log2,
    output t_push  o_push
);

    logic [2:0] r_pend, n_pend;
    logic       r_pnc, n_pnc;
    t_row       r_cur_row, n_cur_row, r_start_row, n_start_row;
    t_col       r_cur_col, n_cur_col, r_start_col, n_start_col;
    t_off       r_start_off, n_start_off;
    t_value     r_acc, n_acc;

    logic   is_digit, is_alpha, is_blank, is_nl, is_tab, is_cr, is_op;
    t_kind  op_kind;
    logic   do_flush, do_new;
    t_token flush_tok, new_tok;

    always_comb begin
        is_digit = i_code_point inside {[CH_ZERO:CH_NINE]};
        is_alpha = (i_code_point inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]})
                   || (i_code_point == CH_UNDER);
        is_tab   = (i_code_point == CH_TAB);
        is_blank = is_tab || (i_code_point == CH_SPACE);
        is_cr    = (i_code_point == CH_CR);
        is_nl    = is_cr || (i_code_point == CH_LF);
        is_op    = 1'b1;
        case (i_code_point)
            CH_COLON:  op_kind = TK_COLON;
            CH_COMMA:  op_kind = TK_COMMA;
            CH_LPAREN: op_kind = TK_LPAREN;
            CH_RPAREN: op_kind = TK_RPAREN;
            CH_EQUALS: op_kind = TK_EQUALS;
            CH_PLUS:   op_kind = TK_PLUS;
            CH_MINUS:  op_kind = TK_MINUS;
            CH_STAR:   op_kind = TK_STAR;
            CH_SLASH:  op_kind = TK_SLASH;
            default: begin
                op_kind = TK_INVALID;
                is_op   = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_pend)
            PK_NEWLINE: flush_tok.kind = TK_NEWLINE;
            PK_BLANKS:  flush_tok.kind = TK_BLANKS;
            PK_NUMBER:  flush_tok.kind = TK_NUMBER;
            default:    flush_tok.kind = TK_IDENT;
        endcase
        flush_tok.begin_row    = r_start_row;
        flush_tok.begin_column = r_start_col;
        flush_tok.end_row      = r_cur_row;
        flush_tok.end_column   = r_cur_col;
        flush_tok.begin_offset = r_start_off;
        flush_tok.number_value = (r_pend == PK_NUMBER) ? r_acc : '0;
        flush_tok.last         = 1'b1;

        new_tok.kind         = op_kind;
        new_tok.begin_row    = r_cur_row;
        new_tok.begin_column = r_cur_col;
        new_tok.end_row      = r_cur_row;
        new_tok.end_column   = sat_inc_col(r_cur_col);
        new_tok.begin_offset = i_byte_offset;
        new_tok.number_value = '0;
        new_tok.last         = 1'b1;
    end

    always_comb begin
        n_pend      = r_pend;
        n_pnc       = r_pnc;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_start_row = r_start_row;
        n_start_col = r_start_col;
        n_start_off = r_start_off;
        n_acc       = r_acc;
        do_flush    = 1'b0;
        do_new      = 1'b0;
        if (i_fire) begin
            if ((r_pend == PK_NEWLINE) && is_nl && (is_cr != r_pnc)) begin
                do_flush = 1'b1;
                n_pend   = PK_NONE;
            end else if ((r_pend == PK_BLANKS) && is_blank) begin
                n_cur_col = advance_blank(r_cur_col, is_tab, i_tab_stop_log2);
            end else if ((r_pend == PK_NUMBER) && is_digit) begin
                n_acc     = (r_acc << 3) + (r_acc << 1) + t_value'(i_code_point[3:0]);
                n_cur_col = sat_inc_col(r_cur_col);
            end else if ((r_pend == PK_IDENT) && (is_alpha || is_digit)) begin
                n_cur_col = sat_inc_col(r_cur_col);
            end else begin
                do_flush = (r_pend != PK_NONE);
                n_pend   = PK_NONE;
                if (i_code_point == CH_END) begin
                    n_cur_row = '0;
                    n_cur_col = '0;
                    n_pnc     = 1'b0;
                    n_acc     = '0;
                end else begin
                    n_start_row = r_cur_row;
                    n_start_col = r_cur_col;
                    n_start_off = i_byte_offset;
                    if (is_nl) begin
                        n_cur_row = sat_inc_row(r_cur_row);
                        n_cur_col = '0;
                        n_pnc     = is_cr;
                        n_pend    = PK_NEWLINE;
                    end else if (is_blank) begin
                        n_cur_col = advance_blank(r_cur_col, is_tab, i_tab_stop_log2);
                        n_pend    = PK_BLANKS;
                    end else if (is_op) begin
                        n_cur_col = sat_inc_col(r_cur_col);
                        do_new    = 1'b1;
                    end else if (is_digit) begin
                        n_acc     = t_value'(i_code_point[3:0]);
                        n_cur_col = sat_inc_col(r_cur_col);
                        n_pend    = PK_NUMBER;
                    end else if (is_alpha) begin
                        n_cur_col = sat_inc_col(r_cur_col);
                        n_pend    = PK_IDENT;
                    end else begin
                        n_cur_col = sat_inc_col(r_cur_col);
                        do_new    = 1'b1;
                    end
                end
            end
        end

        o_push.tok_a = do_flush ? flush_tok : new_tok;
        o_push.tok_b = new_tok;
        if (do_flush && do_new) begin
            o_push.count      = 2'd2;
            o_push.tok_a.last = 1'b0;
        end else if (do_flush || do_new) begin
            o_push.count = 2'd1;
        end else begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= PK_NONE;
            r_pnc       <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_start_row <= '0;
            r_start_col <= '0;
            r_start_off <= '0;
            r_acc       <= '0;
        end else begin
            r_pend      <= n_pend;
            r_pnc       <= n_pnc;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_start_row <= n_start_row;
            r_start_col <= n_start_col;
            r_start_off <= n_start_off;
            r_acc       <= n_acc;
        end
    end

endmodule

@@ rtl/ets_token_fifo.sv @@
// Small token queue that takes up to two tokens per cycle and hands out one.
// Depends on ets_pkg and the assertion macro header.
`include "expression_token_scanner_top_assert.svh"

module ets_token_fifo
    import ets_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_room2,
    output logic   o_valid,
    output t_token o_head
);

    t_token                   r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic                     pop_ok;

    assign o_valid = (r_count != '0);
    assign o_room2 = (r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_PTR_BITS'(i_push.count);
        n_rd_ptr = r_rd_ptr + FIFO_PTR_BITS'(pop_ok);
        n_count  = r_count + FIFO_CNT_BITS'(i_push.count) - FIFO_CNT_BITS'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + FIFO_PTR_BITS'(1)] <= i_push.tok_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ETS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.count != 2'd0, (r_count + FIFO_CNT_BITS'(i_push.count)) <= FIFO_CNT_BITS'(FIFO_DEPTH), "token queue overflow")
    `ETS_ASSERT_IMP(a_pair_kept, i_clk, i_rst_n, o_valid && !o_head.last, r_count >= FIFO_CNT_BITS'(2), "token without its companion in queue")
    `ETS_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, pop_ok && (i_push.count == 2'd0), r_count == $past(r_count) - FIFO_CNT_BITS'(1), "queue count did not drop on pop")

endmodule
